// ===== rtl/core/mda_pkg.sv =====
// Package for the mouse delta accumulator: request codes, field widths
// and reset constants. No dependencies.
package mda_pkg;

    localparam int ACCUM_WIDTH_DEF = 32;

    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int TICK_W   = 63;
    localparam int SCALE_W  = 16;
    localparam int AXIS_W   = 48;
    localparam int COUNT_W  = 32;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 240;

    localparam logic [SCALE_W-1:0] AXIS_SCALE_RESET = 16'd4915;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_PACKET       = 2'd0;
    localparam mode_t MODE_DRAIN_VIEW   = 2'd1;
    localparam mode_t MODE_DRAIN_CURSOR = 2'd2;
    localparam mode_t MODE_IGNORED      = 2'd3;

endpackage

// ===== rtl/core/mouse_delta_accumulator.sv =====
// Mouse delta accumulator top level: packet accumulation, view and cursor
// drains, gain scaling and output register. Depends on mda_pkg.
//
// Channel  | Dir | Handshake                  | Contents
// ---------+-----+----------------------------+---------------------------------
// s_axis   | in  | s_axis_tvalid/tready       | packet or drain request
// m_axis   | out | m_axis_tvalid/tready       | drain result, one per drain
// cfg      | in  | cfg_wr_en                  | axis_scale gain (Q2.14)
//
// One transaction per cycle sustained while no drain is held back. An accepted
// item is held in the input register; state is updated and a drain result is
// loaded into the output register at the edge it leaves, so m_axis_tvalid
// rises at that edge.
// Packets and ignored requests never wait on m_axis_tready; a drain holds in
// the input register only while an earlier result is still unclaimed.
// aresetn is synchronous, active low, and clears all accumulators and flags.
module mouse_delta_accumulator #(
    parameter int ACCUM_WIDTH = mda_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [mda_pkg::SCALE_W-1:0]    cfg_wr_data,   // axis_scale

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // x_value[31:0], y_value[63:32], arrival_tick[126:64], zero [127]
    input  logic [mda_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0], absolute[2]
    input  logic [mda_pkg::S_TUSER_W-1:0]  s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // axis_value[47:0], packets_taken[79:48], span_ticks[142:80],
    // cursor_dx[174:143], cursor_dy[206:175], lifetime_packets[238:207],
    // absolute_notice[239]
    output logic [mda_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import mda_pkg::*;

    // input register
    logic                      in_valid_reg;
    mode_t                     in_mode_reg;
    logic                      in_abs_reg;
    logic [VALUE_W-1:0]        in_x_reg;
    logic [VALUE_W-1:0]        in_y_reg;
    logic [TICK_W-1:0]         in_tick_reg;

    // block state
    logic [SCALE_W-1:0]        axis_scale_reg;
    logic [ACCUM_WIDTH-1:0]    view_accum_reg,      view_accum_next;
    logic [ACCUM_WIDTH-1:0]    cursor_x_reg,        cursor_x_next;
    logic [ACCUM_WIDTH-1:0]    cursor_y_reg,        cursor_y_next;
    logic [COUNT_W-1:0]        packet_total_reg,    packet_total_next;
    logic [COUNT_W-1:0]        since_drain_reg,     since_drain_next;
    logic [TICK_W-1:0]         latest_tick_reg,     latest_tick_next;
    logic [TICK_W-1:0]         drained_tick_reg,    drained_tick_next;
    logic                      drained_valid_reg,   drained_valid_next;
    logic                      have_origin_reg,     have_origin_next;
    logic [VALUE_W-1:0]        origin_x_reg,        origin_x_next;
    logic [VALUE_W-1:0]        origin_y_reg,        origin_y_next;
    logic                      absolute_flag_reg,   absolute_flag_next;
    logic                      notice_given_reg,    notice_given_next;

    // output register
    logic                      out_valid_reg,       out_valid_next;
    logic [M_TDATA_W-1:0]      out_data_reg,        out_data_next;

    logic                      out_free;
    logic                      is_drain;
    logic                      proceed;
    logic                      s_accept;

    logic [VALUE_W-1:0]        dx32;
    logic [VALUE_W-1:0]        dy32;
    logic [ACCUM_WIDTH-1:0]    dx_ext;
    logic [ACCUM_WIDTH-1:0]    dy_ext;
    logic [AXIS_W-1:0]         neg_counts;
    logic [AXIS_W-1:0]         axis_prod;
    logic [TICK_W-1:0]         span;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign is_drain = (in_mode_reg == MODE_DRAIN_VIEW) || (in_mode_reg == MODE_DRAIN_CURSOR);
    assign proceed  = in_valid_reg && (!is_drain || out_free);

    assign s_axis_tready = !in_valid_reg || proceed;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // motion of the packet; absolute positions are differenced against origin
    assign dx32   = in_abs_reg ? (in_x_reg - origin_x_reg) : in_x_reg;
    assign dy32   = in_abs_reg ? (in_y_reg - origin_y_reg) : in_y_reg;
    assign dx_ext = ACCUM_WIDTH'($signed(dx32));
    assign dy_ext = ACCUM_WIDTH'($signed(dy32));

    // -counts * gain, low 48 bits
    assign neg_counts = AXIS_W'(0) - AXIS_W'($signed(view_accum_reg));
    assign axis_prod  = AXIS_W'(neg_counts * AXIS_W'(axis_scale_reg));

    assign span = (drained_valid_reg && (latest_tick_reg > drained_tick_reg))
                  ? (latest_tick_reg - drained_tick_reg) : '0;

    always_comb begin
        view_accum_next    = view_accum_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        packet_total_next  = packet_total_reg;
        since_drain_next   = since_drain_reg;
        latest_tick_next   = latest_tick_reg;
        drained_tick_next  = drained_tick_reg;
        drained_valid_next = drained_valid_reg;
        have_origin_next   = have_origin_reg;
        origin_x_next      = origin_x_reg;
        origin_y_next      = origin_y_reg;
        absolute_flag_next = absolute_flag_reg;
        notice_given_next  = notice_given_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_data_next      = out_data_reg;

        if (proceed) begin
            unique case (in_mode_reg)
                MODE_PACKET: begin
                    if (in_abs_reg) begin
                        absolute_flag_next = 1'b1;
                        origin_x_next      = in_x_reg;
                        origin_y_next      = in_y_reg;
                    end
                    if (in_abs_reg && !have_origin_reg) begin
                        // first absolute position only sets the origin
                        have_origin_next = 1'b1;
                    end else begin
                        view_accum_next   = view_accum_reg + dx_ext;
                        cursor_x_next     = cursor_x_reg + dx_ext;
                        cursor_y_next     = cursor_y_reg + dy_ext;
                        packet_total_next = packet_total_reg + COUNT_W'(1);
                        since_drain_next  = since_drain_reg + COUNT_W'(1);
                        latest_tick_next  = in_tick_reg;
                    end
                end
                MODE_DRAIN_VIEW: begin
                    view_accum_next  = '0;
                    since_drain_next = '0;
                    out_valid_next   = 1'b1;
                    out_data_next    = '0;
                    out_data_next[47:0]    = axis_prod;
                    out_data_next[79:48]   = since_drain_reg;
                    out_data_next[238:207] = packet_total_reg;
                    if (since_drain_reg != '0) begin
                        out_data_next[142:80] = span;
                        drained_tick_next     = latest_tick_reg;
                        drained_valid_next    = 1'b1;
                    end
                    if (absolute_flag_reg && !notice_given_reg) begin
                        notice_given_next  = 1'b1;
                        out_data_next[239] = 1'b1;
                    end
                end
                MODE_DRAIN_CURSOR: begin
                    cursor_x_next  = '0;
                    cursor_y_next  = '0;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[174:143] = VALUE_W'(cursor_x_reg);
                    out_data_next[206:175] = VALUE_W'(cursor_y_reg);
                    out_data_next[238:207] = packet_total_reg;
                end
                default: begin
                    // unused request code: dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            axis_scale_reg    <= AXIS_SCALE_RESET;
            view_accum_reg    <= '0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            packet_total_reg  <= '0;
            since_drain_reg   <= '0;
            latest_tick_reg   <= '0;
            drained_tick_reg  <= '0;
            drained_valid_reg <= 1'b0;
            have_origin_reg   <= 1'b0;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            absolute_flag_reg <= 1'b0;
            notice_given_reg  <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (proceed) begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                axis_scale_reg <= cfg_wr_data;
            end
            view_accum_reg    <= view_accum_next;
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            packet_total_reg  <= packet_total_next;
            since_drain_reg   <= since_drain_next;
            latest_tick_reg   <= latest_tick_next;
            drained_tick_reg  <= drained_tick_next;
            drained_valid_reg <= drained_valid_next;
            have_origin_reg   <= have_origin_next;
            origin_x_reg      <= origin_x_next;
            origin_y_reg      <= origin_y_next;
            absolute_flag_reg <= absolute_flag_next;
            notice_given_reg  <= notice_given_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg <= mode_t'(s_axis_tuser[1:0]);
            in_abs_reg  <= s_axis_tuser[2];
            in_x_reg    <= s_axis_tdata[31:0];
            in_y_reg    <= s_axis_tdata[63:32];
            in_tick_reg <= s_axis_tdata[126:64];
        end
        out_data_reg <= out_data_next;
    end

endmodule
